[sv/bhc_pkg.sv]
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types, register indexes, reset values and the six-step drive table
// for the Hall commutator with slewed duty and PWM gating.
// ----------------------------------------------------------------------------
package bhc_pkg;

	// Drive code for one phase
	typedef enum logic [1:0] {
		DRV_FLOAT = 2'd0,
		DRV_HIGH  = 2'd1,
		DRV_LOW   = 2'd2
	} drive_t;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLEW_INTERVAL = 2'd0,
		CFG_DUTY_CEILING  = 2'd1
	} cfg_idx_t;

	localparam logic [7:0] SLEW_INTERVAL_RST = 8'd100;
	localparam logic [7:0] DUTY_CEILING_RST  = 8'd128;

	// Live configuration
	typedef struct packed {
		logic [7:0] slew_interval;
		logic [7:0] duty_ceiling;
	} cfg_t;

	// Input beat
	typedef struct packed {
		logic [7:0] speed_request;
		logic [6:0] pwm_count;
		logic [2:0] hall_code;
		logic       clockwise;
	} in_item_t;

	// Result beat
	typedef struct packed {
		drive_t     phase_a_drive;
		drive_t     phase_b_drive;
		drive_t     phase_c_drive;
		logic [7:0] duty_level;
	} out_item_t;

	// Drive for all three phases
	typedef struct packed {
		drive_t a;
		drive_t b;
		drive_t c;
	} phase_set_t;

	// Clockwise six-step table; invalid codes (all low, all high) float
	function automatic phase_set_t cw_drive(input logic [2:0] row);
		phase_set_t p;
		case (row)
			3'd1:    p = '{DRV_HIGH,  DRV_LOW,   DRV_FLOAT};
			3'd2:    p = '{DRV_LOW,   DRV_FLOAT, DRV_HIGH};
			3'd3:    p = '{DRV_FLOAT, DRV_LOW,   DRV_HIGH};
			3'd4:    p = '{DRV_FLOAT, DRV_HIGH,  DRV_LOW};
			3'd5:    p = '{DRV_HIGH,  DRV_FLOAT, DRV_LOW};
			3'd6:    p = '{DRV_LOW,   DRV_HIGH,  DRV_FLOAT};
			default: p = '{DRV_FLOAT, DRV_FLOAT, DRV_FLOAT};
		endcase
		return p;
	endfunction

endpackage

[sv/bhc_slew.sv]
// ----------------------------------------------------------------------------
// bhc_slew
// Held duty and slew divider. Computes this pass's updated duty and commits
// it, with the divider, when the pass leaves the input stage.
// ----------------------------------------------------------------------------
module bhc_slew (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [7:0]        speed_request,
	input  bhc_pkg::cfg_t     cfg,
	output logic [7:0]        duty_now,
	output logic [7:0]        duty_next
);

	logic [7:0] duty_q;
	logic [7:0] div_q;
	logic [7:0] div_inc;
	logic [7:0] div_next;

	// Divider counts only while request and duty differ
	always_comb begin
		div_inc   = div_q + 8'd1;
		div_next  = div_q;
		duty_next = duty_q;
		if (speed_request != duty_q) begin
			div_next = div_inc;
			if (div_inc >= cfg.slew_interval) begin
				div_next = '0;
				if (speed_request > duty_q && duty_q < cfg.duty_ceiling) begin
					duty_next = duty_q + 8'd1;
				end else if (speed_request < duty_q && duty_q != 8'd0) begin
					duty_next = duty_q - 8'd1;
				end
			end
		end
	end

	// State commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
			div_q  <= '0;
		end else if (step_en) begin
			duty_q <= duty_next;
			div_q  <= div_next;
		end
	end

	assign duty_now = duty_q;

endmodule

[sv/bhc_commutate.sv]
// ----------------------------------------------------------------------------
// bhc_commutate
// PWM gating and six-step phase selection for one pass.
// ----------------------------------------------------------------------------
module bhc_commutate (
	input  bhc_pkg::in_item_t  item,
	input  logic [7:0]         duty,
	output bhc_pkg::out_item_t result
);

	logic [7:0]          count;
	logic [2:0]          row;
	logic                gate_off;
	bhc_pkg::phase_set_t drv;

	always_comb begin
		// count runs 1..128
		count    = {1'b0, item.pwm_count} + 8'd1;
		gate_off = count > duty;
		// counter-clockwise reads the table at 7 - code
		row      = item.clockwise ? item.hall_code : ~item.hall_code;
		drv      = bhc_pkg::cw_drive(row);
		if (gate_off) begin
			drv = '{bhc_pkg::DRV_FLOAT, bhc_pkg::DRV_FLOAT, bhc_pkg::DRV_FLOAT};
		end
		result.phase_a_drive = drv.a;
		result.phase_b_drive = drv.b;
		result.phase_c_drive = drv.c;
		result.duty_level    = duty;
	end

endmodule

[sv/bldc_hall_commutator_slew_pwm.sv]
// ----------------------------------------------------------------------------
// bldc_hall_commutator_slew_pwm: input register, then duty/table logic, then
// result register. Throughput one beat per cycle unless a held result with
// result_ready low stalls the pipe. Async reset clears duty, divider and valids;
// config regs reset to slew_interval 100 and duty_ceiling 128.
// ----------------------------------------------------------------------------
module bldc_hall_commutator_slew_pwm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  bhc_pkg::in_item_t                 item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output bhc_pkg::out_item_t                result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bhc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                        cfg_data
);

	bhc_pkg::cfg_t      cfg_q;
	bhc_pkg::in_item_t  item_s1;
	logic               valid_s1;
	bhc_pkg::out_item_t result_s2;
	logic               valid_s2;
	logic               adv_s1;
	logic [7:0]         duty_now;
	logic [7:0]         duty_next;
	bhc_pkg::out_item_t result_next;

	// Handshake: stage 1 moves when the result register is free or draining
	assign adv_s1     = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || adv_s1;
	assign cfg_ready  = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slew_interval <= bhc_pkg::SLEW_INTERVAL_RST;
			cfg_q.duty_ceiling  <= bhc_pkg::DUTY_CEILING_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (bhc_pkg::cfg_idx_t'(cfg_index))
				bhc_pkg::CFG_SLEW_INTERVAL: cfg_q.slew_interval <= cfg_data;
				bhc_pkg::CFG_DUTY_CEILING:  cfg_q.duty_ceiling  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) valid_s1 <= item_valid;
			if (!valid_s2 || result_ready) valid_s2 <= valid_s1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) item_s1 <= item;
		if (adv_s1) result_s2 <= result_next;
	end

	bhc_slew u_slew (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (adv_s1),
		.speed_request (item_s1.speed_request),
		.cfg           (cfg_q),
		.duty_now      (duty_now),
		.duty_next     (duty_next)
	);

	bhc_commutate u_commutate (
		.item   (item_s1),
		.duty   (duty_next),
		.result (result_next)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef SYNTHESIS
	// Duty moves by at most one step per cycle
	a_duty_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (duty_now == $past(duty_now) || duty_now == $past(duty_now) + 8'd1 ||
			duty_now == $past(duty_now) - 8'd1))
		else $error("held duty jumped by more than one");

	// Duty only changes when a pass leaves stage 1
	a_duty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(duty_now))
		else $error("held duty changed without a pass");

	// Zero duty always floats every phase
	a_zero_float: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.duty_level == 8'd0) |->
			(result.phase_a_drive == bhc_pkg::DRV_FLOAT &&
			 result.phase_b_drive == bhc_pkg::DRV_FLOAT &&
			 result.phase_c_drive == bhc_pkg::DRV_FLOAT))
		else $error("phase driven at zero duty");

	// A driven step has exactly one high and one low phase
	a_one_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.phase_a_drive != bhc_pkg::DRV_FLOAT ||
			result.phase_b_drive != bhc_pkg::DRV_FLOAT ||
			result.phase_c_drive != bhc_pkg::DRV_FLOAT)) |->
			($countones({result.phase_a_drive == bhc_pkg::DRV_HIGH,
				result.phase_b_drive == bhc_pkg::DRV_HIGH,
				result.phase_c_drive == bhc_pkg::DRV_HIGH}) == 1 &&
			 $countones({result.phase_a_drive == bhc_pkg::DRV_LOW,
				result.phase_b_drive == bhc_pkg::DRV_LOW,
				result.phase_c_drive == bhc_pkg::DRV_LOW}) == 1))
		else $error("invalid phase drive combination");
`endif

endmodule
